// File: hdl/cpir_pkg.sv
// ----------------------------------------------------------------------------
// cpir_pkg
// Shared types, widths, rounding and saturation helpers of the contact pair resolver.
// ----------------------------------------------------------------------------
package cpir_pkg;

  localparam int VEC_W      = 60;  // packed vector field
  localparam int MASS_W     = 16;  // inverse mass, Q4.12
  localparam int FRIC_W     = 13;  // friction factor, Q1.12
  localparam int SUM_W      = 17;  // inverse mass sum
  localparam int FPROD_W    = 26;  // friction product, Q2.24
  localparam int CB_DEFAULT = 20;
  localparam int CB_MAX     = 21;
  localparam int PROJ_W     = 32;  // saturated projection
  localparam int TV_W       = 33;  // tangential velocity
  localparam int PROD_W     = 50;  // operand times inverse mass
  localparam int NUM_W      = 49;  // dividend magnitude
  localparam int QUO_W      = 32;  // quotient bits, one per divider stage
  localparam int REM_W      = 18;  // partial remainder
  localparam int FR_W       = TV_W + FPROD_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam logic [MASS_W-1:0] THRESHOLD_RESET = 16'd1;

  // Division slots per component
  localparam int SLOT_D_A  = 0;
  localparam int SLOT_D_B  = 1;
  localparam int SLOT_RV_A = 2;
  localparam int SLOT_RV_B = 3;
  localparam int SLOT_TV_A = 4;
  localparam int SLOT_TV_B = 5;
  localparam int NSLOT     = 6;

  typedef struct packed {
    logic [MASS_W-1:0] inv_mass_a;
    logic [MASS_W-1:0] inv_mass_b;
    logic [FRIC_W-1:0] friction_a;
    logic [FRIC_W-1:0] friction_b;
    logic [VEC_W-1:0]  contact_point_a;
    logic [VEC_W-1:0]  contact_point_b;
    logic [VEC_W-1:0]  contact_normal;
    logic [VEC_W-1:0]  velocity_a;
    logic [VEC_W-1:0]  velocity_b;
  } contact_t;

  typedef struct packed {
    logic             resolved;
    logic [VEC_W-1:0] shift_a;
    logic [VEC_W-1:0] shift_b;
    logic [VEC_W-1:0] new_velocity_a;
    logic [VEC_W-1:0] new_velocity_b;
  } result_t;

  // Classified word handed from the front end to the back end
  typedef struct packed {
    logic                       res;
    logic [MASS_W-1:0]          ia;
    logic [MASS_W-1:0]          ib;
    logic [SUM_W-1:0]           s;
    logic [FPROD_W-1:0]         f;
    logic [2:0][PROJ_W-1:0]     d;
    logic [2:0][PROJ_W-1:0]     rv;
    logic [2:0][TV_W-1:0]       tv;
    logic [2:0][CB_MAX-1:0]     va;
    logic [2:0][CB_MAX-1:0]     vb;
  } cls_t;

  // Right shift, round to nearest, ties away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [PROJ_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[PROJ_W-1:0];
  endfunction

endpackage

// File: hdl/cpir_stream_if.sv
// ----------------------------------------------------------------------------
// cpir_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface cpir_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/contact_pair_impulse_resolver.sv
// ----------------------------------------------------------------------------
// contact_pair_impulse_resolver
// Resolve one body-pair contact: positional split and velocity exchange.
// ----------------------------------------------------------------------------
// Throughput: one contact word per cycle while the result side does not stall;
//   the 32-stage divider pipelines set the depth, not the rate.
// Reset: clears all valid flags and the queue, and sets the threshold to 1.
// ----------------------------------------------------------------------------
module contact_pair_impulse_resolver #(
  parameter int COMPONENT_BITS = cpir_pkg::CB_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  cpir_stream_if.sink   cfg,
  cpir_stream_if.sink   contact,
  cpir_stream_if.source result
);
  import cpir_pkg::*;

  logic [MASS_W-1:0] threshold;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  cls_t              q_wdata;
  cls_t              q_rdata;

  // Threshold register: always writable, used at the front end's first stage.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      threshold <= MASS_W'(cfg.data);
    end
  end

  // Front end: accept, classify, project onto the normal.
  cpir_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .contact   (contact),
    .threshold (threshold),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Queue: lets the front keep working while the output is stalled.
  cpir_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: divide by the mass sum, apply friction, saturate, deliver.
  cpir_back #(.COMPONENT_BITS(COMPONENT_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .result  (result)
  );

  a_stall_from_queue : assert property (@(posedge clk) disable iff (rst)
    !contact.ready |-> q_full)
    else $error("contact channel stalled with room in the queue");
  a_unresolved_no_shift : assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.data.resolved) |->
      (result.data.shift_a == '0 && result.data.shift_b == '0))
    else $error("unresolved word carries a position shift");
  a_result_hold : assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(result.data)))
    else $error("waiting result word changed before it was taken");

endmodule

// File: hdl/cpir_fifo.sv
// ----------------------------------------------------------------------------
// cpir_fifo
// Short queue of classified words between front end and back end.
// ----------------------------------------------------------------------------
module cpir_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpir_pkg::cls_t wdata,
  output logic           full,
  input  logic           pop,
  output cpir_pkg::cls_t rdata,
  output logic           empty
);
  import cpir_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cls_t          mem [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("word pushed into full queue");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("word popped from empty queue");
  a_count_up : assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue fill count lost a word");

endmodule

// File: hdl/cpir_front.sv
// ----------------------------------------------------------------------------
// cpir_front
// Accept contacts, test the inverse mass sum and project onto the normal.
// ----------------------------------------------------------------------------
module cpir_front #(
  parameter int COMPONENT_BITS = cpir_pkg::CB_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  cpir_stream_if.sink                 contact,
  input  logic [cpir_pkg::MASS_W-1:0] threshold,
  input  logic                        q_full,
  output logic                        q_push,
  output cpir_pkg::cls_t              q_wdata
);
  import cpir_pkg::*;

  localparam int CW  = COMPONENT_BITS;
  localparam int EW  = CW + 1;
  localparam int PRW = EW + CW;
  localparam int DW  = PRW + 2;
  localparam int PW  = 2 * CW - 8;
  localparam int P2W = PW + CW;

  typedef struct packed {
    logic                 res;
    logic [MASS_W-1:0]    ia;
    logic [MASS_W-1:0]    ib;
    logic [SUM_W-1:0]     s;
    logic [FPROD_W-1:0]   f;
    logic [2:0][EW-1:0]   r;
    logic [2:0][CW-1:0]   n;
    logic [2:0][CW-1:0]   va;
    logic [2:0][CW-1:0]   vb;
  } side_t;

  logic [4:0] vld;
  logic       adv;
  side_t      sd0, sd1, sd2, sd3;

  logic [SUM_W-1:0]   s_in;
  logic [FPROD_W-1:0] f_in;
  logic signed [CW-1:0] pa_c [3];
  logic signed [CW-1:0] pb_c [3];
  logic signed [CW-1:0] va_c [3];
  logic signed [CW-1:0] vb_c [3];
  logic signed [EW-1:0] e_c  [3];
  logic signed [EW-1:0] r_c  [3];

  logic [2:0][EW-1:0]    e0;
  logic signed [PRW-1:0] ep_c [3];
  logic signed [PRW-1:0] rp_c [3];
  logic signed [PRW-1:0] ep1  [3];
  logic signed [PRW-1:0] rp1  [3];
  logic signed [DW-1:0]  dp_c, dv_c;
  logic signed [63:0]    p_c, q_c;
  logic signed [PW-1:0]  p2, q2;
  logic signed [P2W-1:0] pn_c [3];
  logic signed [P2W-1:0] qn_c [3];
  logic signed [P2W-1:0] pn3  [3];
  logic signed [P2W-1:0] qn3  [3];
  logic signed [PROJ_W-1:0] d_c  [3];
  logic signed [PROJ_W-1:0] rv_c [3];
  logic signed [TV_W-1:0]   tv_c [3];

  // stall the whole front end only when the last stage cannot unload
  assign adv           = !(vld[4] && q_full);
  assign contact.ready = adv;
  assign q_push        = vld[4] && !q_full;

  assign s_in = {1'b0, contact.data.inv_mass_a} + {1'b0, contact.data.inv_mass_b};
  assign f_in = contact.data.friction_a * contact.data.friction_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_c[i] = contact.data.contact_point_a[i*CW +: CW];
      pb_c[i] = contact.data.contact_point_b[i*CW +: CW];
      va_c[i] = contact.data.velocity_a[i*CW +: CW];
      vb_c[i] = contact.data.velocity_b[i*CW +: CW];
      e_c[i]  = EW'(pb_c[i]) - EW'(pa_c[i]);
      r_c[i]  = EW'(vb_c[i]) - EW'(va_c[i]);
      ep_c[i] = $signed(e0[i]) * $signed(sd0.n[i]);
      rp_c[i] = $signed(sd0.r[i]) * $signed(sd0.n[i]);
      pn_c[i] = p2 * $signed(sd2.n[i]);
      qn_c[i] = q2 * $signed(sd2.n[i]);
      d_c[i]  = sat32(rshr(64'(pn3[i]), 12));
      rv_c[i] = sat32(rshr(64'(qn3[i]), 12));
      tv_c[i] = $signed(sd3.r[i]) - rv_c[i];
    end
    dp_c = ep1[0] + ep1[1] + ep1[2];
    dv_c = rp1[0] + rp1[1] + rp1[2];
    p_c  = rshr(64'(dp_c), 12);
    q_c  = rshr(64'(dv_c), 12);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[3:0], contact.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 0: classify, take differences
      sd0.res <= s_in > {1'b0, threshold};
      sd0.ia  <= contact.data.inv_mass_a;
      sd0.ib  <= contact.data.inv_mass_b;
      sd0.s   <= s_in;
      sd0.f   <= f_in;
      for (int i = 0; i < 3; i++) begin
        e0[i]     <= e_c[i];
        sd0.r[i]  <= r_c[i];
        sd0.n[i]  <= contact.data.contact_normal[i*CW +: CW];
        sd0.va[i] <= va_c[i];
        sd0.vb[i] <= vb_c[i];
      end
      // stage 1: per-axis products with the normal
      sd1 <= sd0;
      for (int i = 0; i < 3; i++) begin
        ep1[i] <= ep_c[i];
        rp1[i] <= rp_c[i];
      end
      // stage 2: dot products
      sd2 <= sd1;
      p2  <= p_c[PW-1:0];
      q2  <= q_c[PW-1:0];
      // stage 3: scale the normal
      sd3 <= sd2;
      for (int i = 0; i < 3; i++) begin
        pn3[i] <= pn_c[i];
        qn3[i] <= qn_c[i];
      end
      // stage 4: saturate and split off the tangential part
      q_wdata.res <= sd3.res;
      q_wdata.ia  <= sd3.ia;
      q_wdata.ib  <= sd3.ib;
      q_wdata.s   <= sd3.s;
      q_wdata.f   <= sd3.f;
      for (int i = 0; i < 3; i++) begin
        q_wdata.d[i]  <= d_c[i];
        q_wdata.rv[i] <= rv_c[i];
        q_wdata.tv[i] <= tv_c[i];
        q_wdata.va[i] <= CB_MAX'($signed(sd3.va[i]));
        q_wdata.vb[i] <= CB_MAX'($signed(sd3.vb[i]));
      end
    end
  end

endmodule

// File: hdl/cpir_div.sv
// ----------------------------------------------------------------------------
// cpir_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cpir_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [cpir_pkg::NUM_W-1:0]  num,
  input  logic [cpir_pkg::SUM_W-1:0]  den,
  output logic [cpir_pkg::QUO_W-1:0]  quo
);
  import cpir_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] acc;
    logic [SUM_W-1:0] den;
  } dstage_t;

  dstage_t st [QUO_W];
  dstage_t init;

  function automatic dstage_t step(input dstage_t a);
    dstage_t        b;
    logic [REM_W:0] t;
    logic [REM_W:0] diff;
    logic           ge;
    t      = {a.rem, a.acc[QUO_W-1]};
    diff   = t - {2'b00, a.den};
    ge     = (t >= {2'b00, a.den});
    b.rem  = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
    b.acc  = {a.acc[QUO_W-2:0], ge};
    b.den  = a.den;
    return b;
  endfunction

  assign init.rem = REM_W'(num[NUM_W-1:QUO_W]);
  assign init.acc = num[QUO_W-1:0];
  assign init.den = den;
  assign quo      = st[QUO_W-1].acc;

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= step(init);
      for (int j = 1; j < QUO_W; j++) begin
        st[j] <= step(st[j-1]);
      end
    end
  end

endmodule

// File: hdl/cpir_back.sv
// ----------------------------------------------------------------------------
// cpir_back
// Split corrections by inverse mass, apply friction, saturate and deliver.
// ----------------------------------------------------------------------------
module cpir_back #(
  parameter int COMPONENT_BITS = cpir_pkg::CB_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  cpir_pkg::cls_t q_rdata,
  output logic           q_pop,
  cpir_stream_if.source  result
);
  import cpir_pkg::*;

  localparam int CW = COMPONENT_BITS;
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -(64'sd1 <<< (CW - 1));

  typedef struct packed {
    logic                    res;
    logic [FPROD_W-1:0]      f;
    logic [2:0][CB_MAX-1:0]  va;
    logic [2:0][CB_MAX-1:0]  vb;
    logic [2:0][NSLOT-1:0]   neg;
  } side_t;

  function automatic logic [CW-1:0] sat_cb(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    return c[CW-1:0];
  endfunction

  logic adv;
  logic v0, v1, v2, vx1, vx2;
  logic vdiv [QUO_W];
  cls_t w0, w1;
  side_t sd2_c;
  side_t sline [QUO_W+1];
  side_t sx1, sx2;

  logic signed [TV_W-1:0]   xs     [3][NSLOT];
  logic [MASS_W-1:0]        ms     [NSLOT];
  logic signed [PROD_W-1:0] prod_c [3][NSLOT];
  logic signed [PROD_W-1:0] prod1  [3][NSLOT];
  logic [PROD_W-1:0]        mag_c  [3][NSLOT];
  logic [NUM_W-1:0]         num2   [3][NSLOT];
  logic [SUM_W-1:0]         den2;
  logic [QUO_W-1:0]         quo    [3][NSLOT];
  logic signed [TV_W-1:0]   qs_c   [3][NSLOT];
  logic signed [TV_W-1:0]   qs1    [3][NSLOT];
  logic signed [TV_W-1:0]   qs2    [3][NSLOT];
  logic signed [FR_W-1:0]   fr_c   [3][2];
  logic signed [FR_W-1:0]   fr2    [3][2];
  logic signed [63:0]       fa_c   [3];
  logic signed [63:0]       fb_c   [3];
  result_t                  out_c;

  // hold everything while the output word waits
  assign adv   = !(result.valid && !result.ready);
  assign q_pop = adv && !q_empty;

  always_comb begin
    ms[SLOT_D_A]  = w0.ia;
    ms[SLOT_D_B]  = w0.ib;
    ms[SLOT_RV_A] = w0.ia;
    ms[SLOT_RV_B] = w0.ib;
    ms[SLOT_TV_A] = w0.ia;
    ms[SLOT_TV_B] = w0.ib;
    for (int i = 0; i < 3; i++) begin
      xs[i][SLOT_D_A]  = TV_W'($signed(w0.d[i]));
      xs[i][SLOT_D_B]  = TV_W'($signed(w0.d[i]));
      xs[i][SLOT_RV_A] = TV_W'($signed(w0.rv[i]));
      xs[i][SLOT_RV_B] = TV_W'($signed(w0.rv[i]));
      xs[i][SLOT_TV_A] = $signed(w0.tv[i]);
      xs[i][SLOT_TV_B] = $signed(w0.tv[i]);
      for (int k = 0; k < NSLOT; k++) begin
        prod_c[i][k] = xs[i][k] * $signed({1'b0, ms[k]});
        mag_c[i][k]  = prod1[i][k][PROD_W-1] ? -prod1[i][k] : prod1[i][k];
        qs_c[i][k]   = sline[QUO_W].neg[i][k] ? -$signed({1'b0, quo[i][k]})
                                               :  $signed({1'b0, quo[i][k]});
      end
      fr_c[i][0] = qs1[i][SLOT_TV_A] * $signed({1'b0, sx1.f});
      fr_c[i][1] = qs1[i][SLOT_TV_B] * $signed({1'b0, sx1.f});
    end
  end

  always_comb begin
    sd2_c.res = w1.res;
    sd2_c.f   = w1.f;
    sd2_c.va  = w1.va;
    sd2_c.vb  = w1.vb;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < NSLOT; k++) begin
        sd2_c.neg[i][k] = prod1[i][k][PROD_W-1];
      end
    end
  end

  // one divider per slot and axis, all fed from stage 2
  for (genvar gi = 0; gi < 3; gi++) begin : g_axis
    for (genvar gk = 0; gk < NSLOT; gk++) begin : g_slot
      cpir_div u_div (
        .clk (clk),
        .en  (adv),
        .num (num2[gi][gk]),
        .den (den2),
        .quo (quo[gi][gk])
      );
    end
  end

  // final sums and saturation
  always_comb begin
    out_c          = '0;
    out_c.resolved = sx2.res;
    for (int i = 0; i < 3; i++) begin
      fa_c[i] = rshr(64'(fr2[i][0]), 24);
      fb_c[i] = rshr(64'(fr2[i][1]), 24);
      if (sx2.res) begin
        out_c.shift_a[i*CW +: CW] = sat_cb(64'(qs2[i][SLOT_D_A]));
        out_c.shift_b[i*CW +: CW] = sat_cb(-64'(qs2[i][SLOT_D_B]));
        out_c.new_velocity_a[i*CW +: CW] =
          sat_cb(64'($signed(sx2.va[i])) + 64'(qs2[i][SLOT_RV_A]) + fa_c[i]);
        out_c.new_velocity_b[i*CW +: CW] =
          sat_cb(64'($signed(sx2.vb[i])) - 64'(qs2[i][SLOT_RV_B]) - fb_c[i]);
      end else begin
        out_c.new_velocity_a[i*CW +: CW] = sx2.va[i][CW-1:0];
        out_c.new_velocity_b[i*CW +: CW] = sx2.vb[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      vx1          <= 1'b0;
      vx2          <= 1'b0;
      result.valid <= 1'b0;
      for (int j = 0; j < QUO_W; j++) begin
        vdiv[j] <= 1'b0;
      end
    end else if (adv) begin
      v0      <= !q_empty;
      v1      <= v0;
      v2      <= v1;
      vdiv[0] <= v2;
      for (int j = 1; j < QUO_W; j++) begin
        vdiv[j] <= vdiv[j-1];
      end
      vx1          <= vdiv[QUO_W-1];
      vx2          <= vx1;
      result.valid <= vx2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w0 <= q_rdata;
      w1 <= w0;
      prod1 <= prod_c;
      den2  <= w1.s;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < NSLOT; k++) begin
          num2[i][k] <= NUM_W'(mag_c[i][k] + PROD_W'(w1.s >> 1));
        end
      end
      // side data runs one stage longer: it enters beside the divider input
      sline[0] <= sd2_c;
      for (int j = 1; j <= QUO_W; j++) begin
        sline[j] <= sline[j-1];
      end
      sx1         <= sline[QUO_W];
      qs1         <= qs_c;
      sx2         <= sx1;
      qs2         <= qs1;
      fr2         <= fr_c;
      result.data <= out_c;
    end
  end

endmodule

// File: dv/tb_contact_pair_impulse_resolver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contact_pair_impulse_resolver
// Streams contacts through the resolver under several thresholds, with
// bursty input and a stalling result side, and checks every result word
// against a fixed-point model of the projection and velocity exchange.
// ----------------------------------------------------------------------------
module tb_contact_pair_impulse_resolver;
  import cpir_pkg::*;

  localparam int  CB        = CB_DEFAULT;
  localparam int  DRAIN_GAP = 60;      // beyond the contact-to-result latency
  localparam int  LIMIT     = 400000;  // cycles before the run is called hung
  localparam int  N_RANDOM  = 1000;

  // Scoreboard: models the resolver and holds the results still owed.
  class contact_scoreboard;
    result_t          owed_q[$];
    logic [MASS_W-1:0] threshold;
    int               errors;

    function new();
      threshold = THRESHOLD_RESET;
      errors    = 0;
    endfunction

    function longint comp(logic [VEC_W-1:0] v, int i);
      logic signed [CB-1:0] c;
      c = v[i*CB +: CB];
      return longint'(c);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Round to nearest, ties away from zero
    function longint round_shift(longint v, int sh);
      longint unsigned m;
      m = v < 0 ? longint'(-v) : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint round_div(longint v, longint d);
      longint unsigned m;
      m = v < 0 ? longint'(-v) : v;
      m = (m + d / 2) / d;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function logic [VEC_W-1:0] pack_sat(longint c[3]);
      logic [VEC_W-1:0] r;
      longint lo, hi;
      lo = -(longint'(1) << (CB - 1));
      hi = (longint'(1) << (CB - 1)) - 1;
      r = '0;
      for (int i = 0; i < 3; i++) r[i*CB +: CB] = CB'(clamp(c[i], lo, hi));
      return r;
    endfunction

    function result_t resolve_contact(contact_t c);
      result_t r;
      longint ia, ib, s, f, dotp, dotv, d, rv, tv, fa, fb;
      longint pa[3], pb[3], n[3], va[3], vb[3], sa[3], sb[3], nva[3], nvb[3];
      ia = c.inv_mass_a;
      ib = c.inv_mass_b;
      s  = ia + ib;
      f  = longint'(c.friction_a) * longint'(c.friction_b);
      for (int i = 0; i < 3; i++) begin
        pa[i] = comp(c.contact_point_a, i);
        pb[i] = comp(c.contact_point_b, i);
        n[i]  = comp(c.contact_normal, i);
        va[i] = comp(c.velocity_a, i);
        vb[i] = comp(c.velocity_b, i);
        sa[i] = 0; sb[i] = 0; nva[i] = va[i]; nvb[i] = vb[i];
      end
      r.resolved = s > longint'(threshold);
      if (r.resolved) begin
        dotp = 0; dotv = 0;
        for (int i = 0; i < 3; i++) begin
          dotp += (pb[i] - pa[i]) * n[i];
          dotv += (vb[i] - va[i]) * n[i];
        end
        dotp = round_shift(dotp, 12);
        dotv = round_shift(dotv, 12);
        for (int i = 0; i < 3; i++) begin
          d  = clamp(round_shift(dotp * n[i], 12), -64'sd2147483648, 64'sd2147483647);
          rv = clamp(round_shift(dotv * n[i], 12), -64'sd2147483648, 64'sd2147483647);
          tv = (vb[i] - va[i]) - rv;
          fa = round_shift(round_div(tv * ia, s) * f, 24);
          fb = round_shift(round_div(tv * ib, s) * f, 24);
          sa[i]  = round_div(d * ia, s);
          sb[i]  = -round_div(d * ib, s);
          nva[i] = va[i] + round_div(rv * ia, s) + fa;
          nvb[i] = vb[i] - round_div(rv * ib, s) - fb;
        end
      end
      r.shift_a        = pack_sat(sa);
      r.shift_b        = pack_sat(sb);
      r.new_velocity_a = pack_sat(nva);
      r.new_velocity_b = pack_sat(nvb);
      return r;
    endfunction

    function void note_contact(contact_t c);
      owed_q = {owed_q, resolve_contact(c)};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result word with nothing owed: %h", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.resolved !== want.resolved) begin
        $display("%0t: resolved exp %0b got %0b", $time, want.resolved, got.resolved);
        errors++;
      end
      if (got.shift_a !== want.shift_a) begin
        $display("%0t: shift_a exp %h got %h", $time, want.shift_a, got.shift_a);
        errors++;
      end
      if (got.shift_b !== want.shift_b) begin
        $display("%0t: shift_b exp %h got %h", $time, want.shift_b, got.shift_b);
        errors++;
      end
      if (got.new_velocity_a !== want.new_velocity_a) begin
        $display("%0t: new_velocity_a exp %h got %h", $time, want.new_velocity_a,
                 got.new_velocity_a);
        errors++;
      end
      if (got.new_velocity_b !== want.new_velocity_b) begin
        $display("%0t: new_velocity_b exp %h got %h", $time, want.new_velocity_b,
                 got.new_velocity_b);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   hold_off = 0;   // cycles left of a forced long result stall

  cpir_stream_if #(.T(logic [MASS_W-1:0])) cfg_if ();
  cpir_stream_if #(.T(contact_t))          contact_if ();
  cpir_stream_if #(.T(result_t))           result_if ();

  contact_scoreboard sb = new();

  contact_pair_impulse_resolver #(.COMPONENT_BITS(CB)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if.sink),
    .contact (contact_if.sink),
    .result  (result_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    contact_if.valid = 1'b0;
    contact_if.data  = '0;
    result_if.ready  = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check each result word as it is taken
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) sb.check_result(result_if.data);
  end

  // Receiver: pick a new random stall pattern periodically; a forced hold overrides it
  int rx_mode = 0;
  always @(negedge clk) begin
    if (cycles % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_off > 0) begin
      hold_off--;
      result_if.ready = 1'b0;
    end else begin
      case (rx_mode)
        0: result_if.ready = 1'b1;
        1: result_if.ready = ($urandom_range(0, 3) != 0);
        2: result_if.ready = ($urandom_range(0, 3) == 0);
        default: result_if.ready = ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  function automatic logic [VEC_W-1:0] vec3(longint x, longint y, longint z);
    logic [VEC_W-1:0] v;
    v = '0;
    v[0 +: CB]    = CB'(x);
    v[CB +: CB]   = CB'(y);
    v[2*CB +: CB] = CB'(z);
    return v;
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec_full();
    return VEC_W'({$urandom, $urandom});
  endfunction

  // Small vector, up to +-range per component
  function automatic logic [VEC_W-1:0] rand_vec_small(int range);
    logic [VEC_W-1:0] v;
    v = vec3($urandom_range(0, 2*range) - range, $urandom_range(0, 2*range) - range,
             $urandom_range(0, 2*range) - range);
    return v;
  endfunction

  function automatic logic [VEC_W-1:0] rand_normal();
    logic [VEC_W-1:0] v;
    int sgn;
    sgn = $urandom_range(0, 1) ? 4096 : -4096;
    case ($urandom_range(0, 3))
      0: v = vec3(sgn, 0, 0);
      1: v = vec3(0, sgn, 0);
      2: v = vec3(0, 0, sgn);
      default: v = vec3(2365 * (sgn / 4096), 2365, -2365);
    endcase
    return v;
  endfunction

  // Hand one word to the contact port; leave valid high on return
  task automatic send_contact(contact_t c);
    contact_if.valid = 1'b1;
    contact_if.data  = c;
    do @(posedge clk); while (!contact_if.ready);
    sb.note_contact(c);
    @(negedge clk);
  endtask

  task automatic idle_contact(int n);
    contact_if.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Hold until nothing is owed, then let the pipeline settle
  task automatic drain();
    idle_contact(0);
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_threshold(logic [MASS_W-1:0] th);
    cfg_if.valid = 1'b1;
    cfg_if.data  = th;
    do @(posedge clk); while (!cfg_if.ready);
    sb.threshold = th;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic contact_t rand_contact();
    contact_t c;
    int kind;
    kind = $urandom_range(0, 9);
    c.inv_mass_a = $urandom_range(0, 3) == 0 ? MASS_W'($urandom)
                                             : MASS_W'($urandom_range(0, 8192));
    c.inv_mass_b = $urandom_range(0, 3) == 0 ? MASS_W'($urandom)
                                             : MASS_W'($urandom_range(0, 8192));
    c.friction_a = $urandom_range(0, 4) == 0 ? FRIC_W'($urandom)
                                             : FRIC_W'($urandom_range(0, 4096));
    c.friction_b = $urandom_range(0, 4) == 0 ? FRIC_W'($urandom)
                                             : FRIC_W'($urandom_range(0, 4096));
    if (kind < 7) begin
      // Plausible contact: small penetration, unit normal, modest speeds
      c.contact_point_a = rand_vec_small(20000) | (VEC_W'($urandom) << 60);
      c.contact_point_b = rand_vec_small(20000);
      c.contact_normal  = rand_normal();
      c.velocity_a      = rand_vec_small(100000);
      c.velocity_b      = rand_vec_small(100000);
    end else begin
      // Anything the fields allow, saturation included
      c.contact_point_a = rand_vec_full();
      c.contact_point_b = rand_vec_full();
      c.contact_normal  = rand_vec_full();
      c.velocity_a      = rand_vec_full();
      c.velocity_b      = rand_vec_full();
    end
    return c;
  endfunction

  // Bursts of random length, often separated by random gaps
  task automatic send_random(int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_contact(rand_contact());
      left -= burst;
      if ($urandom_range(0, 2) != 0) idle_contact($urandom_range(1, 8));
    end
  endtask

  task automatic send_directed();
    contact_t c;
    longint mx, mn;
    mx = (longint'(1) << (CB - 1)) - 1;
    mn = -(longint'(1) << (CB - 1));
    // Both masses zero: never resolved
    c = '0;
    send_contact(c);
    // Sum equal to the reset threshold, then just above it
    c.inv_mass_a = 16'd1; c.contact_normal = vec3(4096, 0, 0);
    c.velocity_a = vec3(100, -200, 300);
    send_contact(c);
    c.inv_mass_b = 16'd1; c.contact_point_b = vec3(4000, 0, 0);
    send_contact(c);
    // Frictionless, full friction and friction beyond 1.0
    c.inv_mass_a = 16'd4096; c.inv_mass_b = 16'd4096;
    c.velocity_b = vec3(-5000, 7000, 1000); c.contact_normal = vec3(0, 4096, 0);
    c.friction_a = 13'd0;    c.friction_b = 13'd4096; send_contact(c);
    c.friction_a = 13'd4096; c.friction_b = 13'd4096; send_contact(c);
    c.friction_a = 13'd8191; c.friction_b = 13'd8191; send_contact(c);
    // Largest masses, one side infinitely heavy
    c.inv_mass_a = 16'hffff; c.inv_mass_b = 16'hffff; send_contact(c);
    c.inv_mass_b = 16'd0; send_contact(c);
    // Component extremes: projection and result saturation
    c.inv_mass_a = 16'h8000; c.inv_mass_b = 16'd1;
    c.contact_point_a = vec3(mn, mn, mn); c.contact_point_b = vec3(mx, mx, mx);
    c.contact_normal  = vec3(mx, mx, mx);
    c.velocity_a = vec3(mn, mn, mn); c.velocity_b = vec3(mx, mx, mx);
    send_contact(c);
    c.contact_normal = vec3(mn, mx, mn); send_contact(c);
    c.velocity_a = vec3(mx, mn, mx); c.velocity_b = vec3(mn, mx, mn); send_contact(c);
    // Every bit of the vector fields set, then of the whole word
    c.contact_point_a = '1; c.contact_point_b = '1; c.contact_normal = '1;
    c.velocity_a = '1; c.velocity_b = '1;
    send_contact(c);
    c = '1;
    send_contact(c);
    idle_contact(0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    write_threshold(THRESHOLD_RESET);
    send_directed();
    send_random(N_RANDOM / 5);
    drain();

    // Zero threshold; stall the receiver long enough to back up the input
    write_threshold(16'd0);
    hold_off = 400;
    send_random(N_RANDOM / 5);
    drain();

    write_threshold(16'hffff);
    send_directed();
    send_random(N_RANDOM / 5);
    drain();

    write_threshold(16'd4096);
    send_random(N_RANDOM / 5);
    drain();

    write_threshold(MASS_W'($urandom));
    send_random(N_RANDOM / 5);
    drain();

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/cpir_pkg.sv
hdl/cpir_stream_if.sv
hdl/cpir_fifo.sv
hdl/cpir_front.sv
hdl/cpir_div.sv
hdl/cpir_back.sv
hdl/contact_pair_impulse_resolver.sv
dv/tb_contact_pair_impulse_resolver.sv
